// File: rtl/core/pcpd_pkg.sv
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared types, constants and the rotation-code function of the preamble
// correlator.
// ----------------------------------------------------------------------------
package pcpd_pkg;

    localparam int PREAMBLE_MAX = 64;
    localparam int PRE_AW       = $clog2(PREAMBLE_MAX);
    localparam int LEN_W        = 7;
    localparam int SEARCH_MAX   = 8192;
    localparam int SLEN_W       = 14;
    localparam int OFF_W        = 13;
    localparam int CNT_W        = 14;
    localparam int SAMPLE_BITS  = 12;
    localparam int COEF_BITS    = 8;
    localparam int PROD_W       = SAMPLE_BITS + COEF_BITS;
    localparam int CORR_W       = 27;
    localparam int MAG_W        = 52;
    localparam int ABS_W        = MAG_W / 2;
    localparam int DRAIN_CYC    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 52;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_QPSK    = 2'd3;

    localparam logic [MAG_W-1:0]  RST_THRESHOLD    = MAG_W'(3600);
    localparam logic [SLEN_W-1:0] RST_SEARCH_LEN   = SLEN_W'(256);
    localparam logic [LEN_W-1:0]  RST_PREAMBLE_LEN = LEN_W'(32);
    localparam logic              RST_MODE_QPSK    = 1'b1;

    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] ROT_P1 = 2'd0;
    localparam logic [1:0] ROT_PJ = 2'd1;
    localparam logic [1:0] ROT_M1 = 2'd2;
    localparam logic [1:0] ROT_MJ = 2'd3;

    localparam logic [1:0] QUAD_A = 2'd0;
    localparam logic [1:0] QUAD_B = 2'd1;
    localparam logic [1:0] QUAD_C = 2'd2;
    localparam logic [1:0] QUAD_D = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } t_sample;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] re;
        logic signed [COEF_BITS-1:0] im;
    } t_coef;

    typedef struct packed {
        logic shift;
        logic rot;
    } t_cell_ctl;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

    function automatic logic [1:0] rotation_code(
        input logic signed [CORR_W-1:0] x_in,
        input logic signed [CORR_W-1:0] y_in,
        input logic                     qpsk
    );
        logic signed [CORR_W:0] x;
        logic signed [CORR_W:0] y;
        logic [1:0]             q;
        logic [1:0]             code;
        x = (CORR_W+1)'(x_in);
        y = (CORR_W+1)'(y_in);
        if ((x == '0 && y == '0) || (y <= x && y > -x)) begin
            q = QUAD_A;
        end else if (y > x && y >= -x) begin
            q = QUAD_B;
        end else if (y < -x && y >= x) begin
            q = QUAD_C;
        end else begin
            q = QUAD_D;
        end
        unique case (q)
            QUAD_A:  code = qpsk ? ROT_PJ : ROT_M1;
            QUAD_B:  code = qpsk ? ROT_P1 : ROT_PJ;
            QUAD_C:  code = qpsk ? ROT_MJ : ROT_P1;
            default: code = qpsk ? ROT_M1 : ROT_MJ;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/preamble_correlator_phase_detect.sv
// ----------------------------------------------------------------------------
// preamble_correlator_phase_detect
// Preamble cross-correlation search with peak tracking and rotation code.
// ----------------------------------------------------------------------------
// A coefficient write is taken in the idle state, as is a sample that arrives
// before the window holds preamble_len samples. Every other sample starts a
// pass, and no new beat is taken until it ends: the 64-tap sample ring
// circulates once past a single complex MAC that reads the coefficient RAM,
// then the multiply/accumulate/square pipeline drains and a compare state
// follows, with an emit state that waits on a pending result when the sample
// closes the window. One result beat is produced per window of search_len
// offsets; the output register holds it while the next samples are taken.
module preamble_correlator_phase_detect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pcpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic [pcpd_pkg::PRE_AW-1:0]         i_coef_index,
    input  logic signed [pcpd_pkg::COEF_BITS-1:0]   i_coef_re,
    input  logic signed [pcpd_pkg::COEF_BITS-1:0]   i_coef_im,
    input  logic signed [pcpd_pkg::SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [pcpd_pkg::SAMPLE_BITS-1:0] i_sample_im,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [pcpd_pkg::OFF_W-1:0]          o_peak_offset,
    output logic [1:0]                          o_rotation,
    output logic [pcpd_pkg::MAG_W-1:0]          o_peak_mag_sq
);
    import pcpd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROT   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [PRE_AW-1:0]        r_step;
    logic [PRE_AW-1:0]        n_step;
    logic [CNT_W-1:0]         r_count;
    logic [MAG_W-1:0]         r_best_mag;
    logic [OFF_W-1:0]         r_best_off;
    logic signed [CORR_W-1:0] r_best_re;
    logic signed [CORR_W-1:0] r_best_im;
    logic [MAG_W-1:0]         r_thr;
    logic [SLEN_W-1:0]        r_slen;
    logic [LEN_W-1:0]         r_plen;
    logic                     r_qpsk;
    t_sample                  r_tap;
    logic                     r_tap_vld;
    logic                     r_out_vld;
    logic                     r_found;
    logic [OFF_W-1:0]         r_off_out;
    logic [1:0]               r_rot_out;
    logic [MAG_W-1:0]         r_mag_out;

    logic                     w_acc;
    logic                     w_coef_wr;
    logic                     w_smp;
    logic [LEN_W-1:0]         w_len;
    logic [SLEN_W-1:0]        w_slen;
    logic [CNT_W-1:0]         w_cnt_inc;
    logic                     w_need_corr;
    logic [LEN_W-1:0]         w_raddr_full;
    logic [CNT_W-1:0]         w_off;
    logic                     w_last;
    logic                     w_out_free;
    logic                     w_emit;
    logic                     w_found;
    logic [2*COEF_BITS-1:0]   w_rdata;
    t_coef                    w_coef;
    t_sample                  w_new;
    t_sample                  w_tap [PREAMBLE_MAX];
    t_cell_ctl                w_cell_ctl;
    t_mac_ctl                 w_mac_ctl;
    logic signed [CORR_W-1:0] w_corr_re;
    logic signed [CORR_W-1:0] w_corr_im;
    logic [MAG_W-1:0]         w_mag;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_coef_wr  = w_acc && (i_func == FUNC_COEF);
    assign w_smp      = w_acc && (i_func == FUNC_SAMPLE);

    assign w_len  = (r_plen == '0) ? LEN_W'(1) :
                    (r_plen > LEN_W'(PREAMBLE_MAX)) ? LEN_W'(PREAMBLE_MAX) : r_plen;
    assign w_slen = (r_slen == '0) ? SLEN_W'(1) :
                    (r_slen > SLEN_W'(SEARCH_MAX)) ? SLEN_W'(SEARCH_MAX) : r_slen;

    assign w_cnt_inc    = r_count + CNT_W'(1);
    assign w_need_corr  = w_cnt_inc >= CNT_W'(w_len);
    assign w_raddr_full = w_len - LEN_W'(1) - LEN_W'(r_step);
    assign w_off        = r_count - CNT_W'(w_len);
    assign w_last       = (w_off + CNT_W'(1)) >= CNT_W'(w_slen);
    assign w_out_free   = !r_out_vld || i_out_ready;
    assign w_emit       = (r_state == S_EMIT) && w_out_free;
    assign w_found      = r_best_mag >= r_thr;

    // coefficient store
    pcpd_ram #(
        .WIDTH (2 * COEF_BITS),
        .DEPTH (PREAMBLE_MAX)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_wr),
        .i_waddr (i_coef_index),
        .i_wdata ({i_coef_re, i_coef_im}),
        .i_raddr (w_raddr_full[PRE_AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_coef = t_coef'(w_rdata);

    // sample ring
    assign w_new.re         = i_sample_re;
    assign w_new.im         = i_sample_im;
    assign w_cell_ctl.shift = w_smp;
    assign w_cell_ctl.rot   = (r_state == S_ROT);

    for (genvar j = 0; j < PREAMBLE_MAX; j++) begin : g_cell
        localparam int NXT = (j + 1) % PREAMBLE_MAX;
        t_sample w_prev;
        if (j == 0) begin : g_head
            assign w_prev = w_new;
        end else begin : g_body
            assign w_prev = w_tap[j-1];
        end
        pcpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cell_ctl),
            .i_prev  (w_prev),
            .i_next  (w_tap[NXT]),
            .o_q     (w_tap[j])
        );
    end

    always_ff @(posedge i_clk) begin
        r_tap <= w_tap[0];
    end

    assign w_mac_ctl.clr = w_smp;
    assign w_mac_ctl.vld = r_tap_vld;

    pcpd_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mac_ctl),
        .i_tap     (r_tap),
        .i_coef    (w_coef),
        .o_corr_re (w_corr_re),
        .o_corr_im (w_corr_im),
        .o_mag_sq  (w_mag)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_smp && w_need_corr) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                n_step = r_step + PRE_AW'(1);
                if (r_step == PRE_AW'(PREAMBLE_MAX - 1)) begin
                    n_state = S_DRAIN;
                    n_step  = '0;
                end
            end
            S_DRAIN: begin
                n_step = r_step + PRE_AW'(1);
                if (r_step == PRE_AW'(DRAIN_CYC - 1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = w_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_tap_vld <= 1'b0;
            r_count   <= '0;
            r_best_mag <= '0;
            r_best_off <= '0;
            r_best_re <= '0;
            r_best_im <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_tap_vld <= (r_state == S_ROT) && (LEN_W'(r_step) < w_len);
            if (w_smp) begin
                r_count <= w_cnt_inc;
            end
            if ((r_state == S_CMP) && (w_mag > r_best_mag)) begin
                r_best_mag <= w_mag;
                r_best_off <= w_off[OFF_W-1:0];
                r_best_re  <= w_corr_re;
                r_best_im  <= w_corr_im;
            end
            if (w_emit) begin
                r_count    <= '0;
                r_best_mag <= '0;
                r_best_off <= '0;
                r_best_re  <= '0;
                r_best_im  <= '0;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_found   <= w_found;
            r_off_out <= r_best_off;
            r_rot_out <= w_found ? rotation_code(r_best_re, r_best_im, r_qpsk) : ROT_P1;
            r_mag_out <= r_best_mag;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= RST_THRESHOLD;
            r_slen <= RST_SEARCH_LEN;
            r_plen <= RST_PREAMBLE_LEN;
            r_qpsk <= RST_MODE_QPSK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD:    r_thr  <= i_cfg_data[MAG_W-1:0];
                REG_SEARCH_LEN:   r_slen <= i_cfg_data[SLEN_W-1:0];
                REG_PREAMBLE_LEN: r_plen <= i_cfg_data[LEN_W-1:0];
                REG_MODE_QPSK:    r_qpsk <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_found       = r_found;
    assign o_peak_offset = r_off_out;
    assign o_rotation    = r_rot_out;
    assign o_peak_mag_sq = r_mag_out;

endmodule

// File: rtl/core/pcpd_ram.sv
// ----------------------------------------------------------------------------
// pcpd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pcpd_cell.sv
// ----------------------------------------------------------------------------
// pcpd_cell
// One tap of the sample ring: loads from its upstream neighbor on a new
// sample, from its downstream neighbor while the ring circulates.
// ----------------------------------------------------------------------------
module pcpd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcpd_pkg::t_cell_ctl i_ctl,
    input  pcpd_pkg::t_sample   i_prev,
    input  pcpd_pkg::t_sample   i_next,
    output pcpd_pkg::t_sample   o_q
);
    import pcpd_pkg::*;

    t_sample r_q;
    t_sample n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.shift) begin
            n_q = i_prev;
        end else if (i_ctl.rot) begin
            n_q = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/core/pcpd_mac.sv
// ----------------------------------------------------------------------------
// pcpd_mac
// Complex multiply-accumulate with squared-magnitude output.
// Stages: products, accumulate, squares, sum.
// ----------------------------------------------------------------------------
module pcpd_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcpd_pkg::t_mac_ctl                  i_ctl,
    input  pcpd_pkg::t_sample                   i_tap,
    input  pcpd_pkg::t_coef                     i_coef,
    output logic signed [pcpd_pkg::CORR_W-1:0]  o_corr_re,
    output logic signed [pcpd_pkg::CORR_W-1:0]  o_corr_im,
    output logic [pcpd_pkg::MAG_W-1:0]          o_mag_sq
);
    import pcpd_pkg::*;

    logic                     r_pvld;
    logic signed [PROD_W-1:0] r_ac;
    logic signed [PROD_W-1:0] r_bd;
    logic signed [PROD_W-1:0] r_ad;
    logic signed [PROD_W-1:0] r_bc;
    logic signed [CORR_W-1:0] r_re;
    logic signed [CORR_W-1:0] r_im;
    logic [MAG_W-1:0]         r_sq_re;
    logic [MAG_W-1:0]         r_sq_im;
    logic [MAG_W-1:0]         r_mag;
    logic [ABS_W-1:0]         w_abs_re;
    logic [ABS_W-1:0]         w_abs_im;
    logic [MAG_W:0]           w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ac <= i_coef.re * i_tap.re;
        r_bd <= i_coef.im * i_tap.im;
        r_ad <= i_coef.re * i_tap.im;
        r_bc <= i_coef.im * i_tap.re;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_re <= '0;
            r_im <= '0;
        end else if (r_pvld) begin
            r_re <= r_re + CORR_W'(r_ac) - CORR_W'(r_bd);
            r_im <= r_im + CORR_W'(r_ad) + CORR_W'(r_bc);
        end
    end

    assign w_abs_re = r_re[CORR_W-1] ? ABS_W'(-r_re) : ABS_W'(r_re);
    assign w_abs_im = r_im[CORR_W-1] ? ABS_W'(-r_im) : ABS_W'(r_im);
    assign w_sum    = {1'b0, r_sq_re} + {1'b0, r_sq_im};

    always_ff @(posedge i_clk) begin
        r_sq_re <= w_abs_re * w_abs_re;
        r_sq_im <= w_abs_im * w_abs_im;
        r_mag   <= w_sum[MAG_W] ? '1 : w_sum[MAG_W-1:0];
    end

    assign o_corr_re = r_re;
    assign o_corr_im = r_im;
    assign o_mag_sq  = r_mag;

endmodule

// File: test/peak_report_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_report_checker
// Watches the sample, coefficient and register traffic of the preamble
// correlator, tracks the correlation peak of every search window on its own
// copy of the state and compares each result beat field by field with the
// oldest predicted peak report.
// ----------------------------------------------------------------------------
module peak_report_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [pcpd_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic                                    i_func,
    input  logic [pcpd_pkg::PRE_AW-1:0]             i_coef_index,
    input  logic signed [pcpd_pkg::COEF_BITS-1:0]   i_coef_re,
    input  logic signed [pcpd_pkg::COEF_BITS-1:0]   i_coef_im,
    input  logic signed [pcpd_pkg::SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [pcpd_pkg::SAMPLE_BITS-1:0] i_sample_im,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic                                    i_found,
    input  logic [pcpd_pkg::OFF_W-1:0]              i_peak_offset,
    input  logic [1:0]                              i_rotation,
    input  logic [pcpd_pkg::MAG_W-1:0]              i_peak_mag_sq,
    output int                                      o_mismatch_count,
    output int                                      o_pending
);
    import pcpd_pkg::*;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
        logic [1:0]       rotation;
        logic [MAG_W-1:0] mag_sq;
    } t_peak_report;

    localparam longint MAG_LIMIT = (64'sd1 <<< MAG_W) - 1;

    logic signed [COEF_BITS-1:0]   pre_re_q [PREAMBLE_MAX];
    logic signed [COEF_BITS-1:0]   pre_im_q [PREAMBLE_MAX];
    logic signed [SAMPLE_BITS-1:0] ring_re [PREAMBLE_MAX];
    logic signed [SAMPLE_BITS-1:0] ring_im [PREAMBLE_MAX];
    int                            n_taken;
    logic [MAG_W-1:0]              peak_mag;
    logic [OFF_W-1:0]              peak_off;
    longint                        peak_re;
    longint                        peak_im;

    logic [MAG_W-1:0]  thr_q;
    logic [SLEN_W-1:0] slen_q;
    logic [LEN_W-1:0]  plen_q;
    logic              qpsk_q;

    t_peak_report peak_reports[$];
    t_peak_report want;

    function automatic logic [MAG_W-1:0] power_of(longint re, longint im);
        longint a;
        longint b;
        longint s;
        a = (re < 0) ? -re : re;
        b = (im < 0) ? -im : im;
        if (a >= (64'sd1 <<< ABS_W) || b >= (64'sd1 <<< ABS_W))
            return '1;
        s = a * a + b * b;
        if (s > MAG_LIMIT)
            return '1;
        return s[MAG_W-1:0];
    endfunction

    // phase quadrant of x + jy, then the per-mode correction code
    function automatic logic [1:0] rotation_for(longint x, longint y, logic qpsk);
        logic [1:0] quad;
        if (x == 0 && y == 0)
            quad = QUAD_A;
        else if (y <= x && y > -x)
            quad = QUAD_A;
        else if (y > x && y >= -x)
            quad = QUAD_B;
        else if (y < -x && y >= x)
            quad = QUAD_C;
        else
            quad = QUAD_D;
        case (quad)
            QUAD_A:  return qpsk ? ROT_PJ : ROT_M1;
            QUAD_B:  return qpsk ? ROT_P1 : ROT_PJ;
            QUAD_C:  return qpsk ? ROT_MJ : ROT_P1;
            default: return qpsk ? ROT_M1 : ROT_MJ;
        endcase
    endfunction

    task automatic clear_window();
        n_taken  = 0;
        peak_mag = '0;
        peak_off = '0;
        peak_re  = 0;
        peak_im  = 0;
    endtask

    task automatic take_sample(logic signed [SAMPLE_BITS-1:0] sre,
                               logic signed [SAMPLE_BITS-1:0] sim);
        int               len;
        int               span;
        int               off;
        longint           acc_re;
        longint           acc_im;
        logic [MAG_W-1:0] m;
        t_peak_report     rep;
        for (int i = PREAMBLE_MAX - 1; i > 0; i--) begin
            ring_re[i] = ring_re[i-1];
            ring_im[i] = ring_im[i-1];
        end
        ring_re[0] = sre;
        ring_im[0] = sim;
        n_taken++;
        len  = (plen_q == 0) ? 1 : ((plen_q > PREAMBLE_MAX) ? PREAMBLE_MAX : int'(plen_q));
        span = (slen_q == 0) ? 1 : ((slen_q > SEARCH_MAX) ? SEARCH_MAX : int'(slen_q));
        if (n_taken < len)
            return;
        off    = n_taken - len;
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < len; k++) begin
            acc_re += longint'(pre_re_q[k]) * longint'(ring_re[len-1-k])
                    - longint'(pre_im_q[k]) * longint'(ring_im[len-1-k]);
            acc_im += longint'(pre_re_q[k]) * longint'(ring_im[len-1-k])
                    + longint'(pre_im_q[k]) * longint'(ring_re[len-1-k]);
        end
        m = power_of(acc_re, acc_im);
        if (m > peak_mag) begin
            peak_mag = m;
            peak_off = OFF_W'(off);
            peak_re  = acc_re;
            peak_im  = acc_im;
        end
        if (off + 1 < span)
            return;
        rep.found    = (peak_mag >= thr_q);
        rep.offset   = peak_off;
        rep.rotation = rep.found ? rotation_for(peak_re, peak_im, qpsk_q) : ROT_P1;
        rep.mag_sq   = peak_mag;
        peak_reports.push_back(rep);
        clear_window();
    endtask

    task automatic check_field(string what, logic [MAG_W-1:0] exp_v, logic [MAG_W-1:0] got_v);
        if (exp_v !== got_v) begin
            o_mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PREAMBLE_MAX; i++) begin
                pre_re_q[i] = '0;
                pre_im_q[i] = '0;
                ring_re[i]  = '0;
                ring_im[i]  = '0;
            end
            clear_window();
            thr_q  = RST_THRESHOLD;
            slen_q = RST_SEARCH_LEN;
            plen_q = RST_PREAMBLE_LEN;
            qpsk_q = RST_MODE_QPSK;
            peak_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD:    thr_q  = i_cfg_data[MAG_W-1:0];
                    REG_SEARCH_LEN:   slen_q = i_cfg_data[SLEN_W-1:0];
                    REG_PREAMBLE_LEN: plen_q = i_cfg_data[LEN_W-1:0];
                    REG_MODE_QPSK:    qpsk_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_func == FUNC_COEF) begin
                    pre_re_q[i_coef_index] = i_coef_re;
                    pre_im_q[i_coef_index] = i_coef_im;
                end else begin
                    take_sample(i_sample_re, i_sample_im);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (peak_reports.size() == 0) begin
                    o_mismatch_count++;
                    $display({"%0t: unexpected result beat, expected none, got found=%0d",
                              " offset=%0d rotation=%0d mag_sq=%0d"},
                             $time, i_found, i_peak_offset, i_rotation, i_peak_mag_sq);
                end else begin
                    want = peak_reports.pop_front();
                    check_field("found", MAG_W'(want.found), MAG_W'(i_found));
                    check_field("peak_offset", MAG_W'(want.offset), MAG_W'(i_peak_offset));
                    check_field("rotation", MAG_W'(want.rotation), MAG_W'(i_rotation));
                    check_field("peak_mag_sq", want.mag_sq, i_peak_mag_sq);
                end
            end
        end
        o_pending = peak_reports.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the preamble correlator. Loads the preamble store,
// runs directed probes of the quadrant boundaries, ties and threshold, then
// random phases of noise and rotated preamble bursts over a range of register
// settings and idle patterns. Checking is done by peak_report_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import pcpd_pkg::*;

    localparam int SETTLE_CYC = 100;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [CFG_IDX_W-1:0]          i_cfg_idx;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_func;
    logic [PRE_AW-1:0]             i_coef_index;
    logic signed [COEF_BITS-1:0]   i_coef_re;
    logic signed [COEF_BITS-1:0]   i_coef_im;
    logic signed [SAMPLE_BITS-1:0] i_sample_re;
    logic signed [SAMPLE_BITS-1:0] i_sample_im;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_found;
    logic [OFF_W-1:0]              o_peak_offset;
    logic [1:0]                    o_rotation;
    logic [MAG_W-1:0]              o_peak_mag_sq;

    int mismatch_total;
    int reports_pending;
    int snd_idle_pct;
    int rcv_idle_pct;
    int coef_re_mem [PREAMBLE_MAX];
    int coef_im_mem [PREAMBLE_MAX];

    preamble_correlator_phase_detect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_coef_index  (i_coef_index),
        .i_coef_re     (i_coef_re),
        .i_coef_im     (i_coef_im),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_peak_offset (o_peak_offset),
        .o_rotation    (o_rotation),
        .o_peak_mag_sq (o_peak_mag_sq)
    );

    peak_report_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_coef_index     (i_coef_index),
        .i_coef_re        (i_coef_re),
        .i_coef_im        (i_coef_im),
        .i_sample_re      (i_sample_re),
        .i_sample_im      (i_sample_im),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_found          (o_found),
        .i_peak_offset    (o_peak_offset),
        .i_rotation       (o_rotation),
        .i_peak_mag_sq    (o_peak_mag_sq),
        .o_mismatch_count (mismatch_total),
        .o_pending        (reports_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        return v >>> $urandom_range(0, SAMPLE_BITS - 1);
    endfunction

    task automatic send_beat(logic func, logic [PRE_AW-1:0] idx,
                             logic signed [COEF_BITS-1:0] cre,
                             logic signed [COEF_BITS-1:0] cim,
                             logic signed [SAMPLE_BITS-1:0] sre,
                             logic signed [SAMPLE_BITS-1:0] sim);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_coef_index <= idx;
        i_coef_re    <= cre;
        i_coef_im    <= cim;
        i_sample_re  <= sre;
        i_sample_im  <= sim;
        if (func == FUNC_COEF) begin
            coef_re_mem[idx] = cre;
            coef_im_mem[idx] = cim;
        end
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic probe(logic signed [SAMPLE_BITS-1:0] sre,
                         logic signed [SAMPLE_BITS-1:0] sim);
        send_beat(FUNC_SAMPLE, '0, '0, '0, sre, sim);
    endtask

    task automatic random_coef();
        send_beat(FUNC_COEF, PRE_AW'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
                  rand_sample(), rand_sample());
    endtask

    task automatic random_sample();
        send_beat(FUNC_SAMPLE, PRE_AW'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
                  rand_sample(), rand_sample());
    endtask

    // conjugated preamble, scaled and turned by a multiple of 90 degrees;
    // about a quarter of the bursts are cut short
    task automatic send_burst(int len, output int sent);
        int turns;
        int gain;
        int xr;
        int xi;
        int tmp;
        turns = $urandom_range(3);
        gain  = $urandom_range(1, 15);
        sent  = ($urandom_range(3) == 0) ? $urandom_range(1, len) : len;
        for (int k = 0; k < sent; k++) begin
            xr = coef_re_mem[k] * gain;
            xi = -coef_im_mem[k] * gain;
            repeat (turns) begin
                tmp = xr;
                xr  = -xi;
                xi  = tmp;
            end
            send_beat(FUNC_SAMPLE, PRE_AW'($urandom), COEF_BITS'($urandom),
                      COEF_BITS'($urandom), SAMPLE_BITS'(xr), SAMPLE_BITS'(xi));
        end
    endtask

    task automatic random_beats(int n, int len);
        int done;
        int pick;
        int sent;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                random_coef();
                done++;
            end else if (pick < 30) begin
                send_burst(len, sent);
                done += sent;
            end else begin
                random_sample();
                done++;
            end
        end
    endtask

    // drop valid, wait for every outstanding report, then let the block drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (reports_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [MAG_W-1:0] thr, int slen, int plen, logic qpsk);
        settle();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_SEARCH_LEN, CFG_DATA_W'(slen));
        write_reg(REG_PREAMBLE_LEN, CFG_DATA_W'(plen));
        write_reg(REG_MODE_QPSK, CFG_DATA_W'(qpsk));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [MAG_W-1:0] thr, int slen, int plen, logic qpsk, int n);
        program_regs(thr, slen, plen, qpsk);
        random_beats(n, (plen == 0) ? 1 : ((plen > PREAMBLE_MAX) ? PREAMBLE_MAX : plen));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_func       = FUNC_COEF;
        i_coef_index = '0;
        i_coef_re    = '0;
        i_coef_im    = '0;
        i_sample_re  = '0;
        i_sample_im  = '0;
        i_out_ready  = 1'b0;
        snd_idle_pct = 18;
        rcv_idle_pct = 69;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill the whole preamble store before any sample is correlated
        for (int i = 0; i < PREAMBLE_MAX; i++)
            send_beat(FUNC_COEF, PRE_AW'(i), COEF_BITS'($urandom), COEF_BITS'($urandom),
                      '0, '0);

        // single tap of +1, one offset per window: the result is the sample
        program_regs('0, 0, 0, 1'b1);
        send_beat(FUNC_COEF, '0, 8'sd1, 8'sd0, '0, '0);
        probe(12'sd0, 12'sd0);
        probe(12'sd2047, 12'sd2047);
        probe(12'sd2047, -12'sd2048);
        probe(-12'sd2048, 12'sd2047);
        probe(-12'sd2048, -12'sd2048);
        probe(12'sd100, 12'sd0);
        probe(12'sd0, 12'sd100);
        probe(-12'sd100, 12'sd0);
        probe(12'sd0, -12'sd100);
        probe(12'sd7, 12'sd7);
        probe(-12'sd7, 12'sd7);
        probe(-12'sd7, -12'sd7);
        probe(12'sd7, -12'sd7);

        // equal peaks keep the first; below threshold gives no rotation
        program_regs(MAG_W'(26), 3, 1, 1'b0);
        probe(12'sd3, 12'sd4);
        probe(12'sd5, 12'sd0);
        probe(12'sd4, 12'sd3);
        probe(12'sd1, 12'sd0);
        probe(12'sd6, 12'sd0);
        probe(12'sd0, 12'sd6);
        send_beat(FUNC_COEF, PRE_AW'(PREAMBLE_MAX - 1), -8'sd128, 8'sd127, '0, '0);
        send_beat(FUNC_COEF, '0, 8'sd127, -8'sd128, '0, '0);

        run_phase(MAG_W'(3600), 256, 32, 1'b1, 330);
        run_phase(MAG_W'(1) << 20, 8, 4, 1'b0, 200);
        run_phase('0, 1, 64, 1'b1, 150);

        snd_idle_pct = 69;
        rcv_idle_pct = 18;
        // window left open at the largest span, then closed by a short one
        run_phase('1, 16383, 127, 1'b0, 120);
        run_phase(MAG_W'(1) << 24, 40, 16, 1'b1, 250);
        run_phase(MAG_W'(5_000_000), 5, 2, 1'b0, 200);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(MAG_W'(1) << 30, 12, 8, 1'b1, 200);
        run_phase('0, 2, 1, 1'b0, 200);

        settle();
        if (mismatch_total == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
